>>> hdl/timer_queue_scheduler_defines.svh
// ----------------------------------------------------------------------------
// timer_queue_scheduler_defines
// Assertion macros used by the timer queue scheduler datapath.
// ----------------------------------------------------------------------------
`ifndef TIMER_QUEUE_SCHEDULER_DEFINES_SVH
`define TIMER_QUEUE_SCHEDULER_DEFINES_SVH
// assert an implication on every clock edge outside reset
`define TQS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// assert an implication in the cycle after the antecedent
`define TQS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> hdl/tqs_pkg.sv
// ----------------------------------------------------------------------------
// tqs_pkg
// Shared types and constants of the timer queue scheduler.
// ----------------------------------------------------------------------------
package tqs_pkg;
   localparam int SLOTS_DEF       = 16;
   localparam int HANDLE_BITS_DEF = 16;
   localparam int TIME_BITS_DEF   = 40;
   localparam logic [26:0] DAY_MS = 27'd86400000;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic KIND_FIRED = 1'b0;
   localparam logic KIND_ADD   = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request, advance time on tick
      logic do_add;    // store into free slot / reply
      logic do_cancel;
      logic do_clear;
      logic scan_clr;  // reset running best
      logic scan_step; // compare one slot
      logic fire;      // emit best and retire/re-arm it
   } tqs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic found;
   } tqs_sts_type;
endpackage

>>> hdl/tqs_ctrl.sv
// ----------------------------------------------------------------------------
// tqs_ctrl
// Sequencer: decode request, run one scan per fired timer plus a final one, pace output.
// ----------------------------------------------------------------------------
module tqs_ctrl
   import tqs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic        out_busy,
   input  tqs_sts_type sts,
   output tqs_cmd_type cmd
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_FIRE = 4'b0100,
      ST_OP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = req_operation;
               if (req_operation == OP_TICK) begin
                  cmd.scan_clr = 1'b1;
                  state_in     = ST_SCAN;
               end else begin
                  state_in = ST_OP;
               end
            end
         end
         ST_OP: begin
            // add needs the output register free
            if (op_ff == OP_ADD) begin
               if (!out_busy) begin
                  cmd.do_add = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.do_cancel = (op_ff == OP_CANCEL);
               cmd.do_clear  = (op_ff == OP_CLEAR);
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = ST_FIRE;
         end
         ST_FIRE: begin
            if (!sts.found) begin
               state_in = ST_IDLE;
            end else if (!out_busy) begin
               cmd.fire     = 1'b1;
               cmd.scan_clr = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_TICK;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end
endmodule

>>> hdl/tqs_datapath.sv
// ----------------------------------------------------------------------------
// tqs_datapath
// Slot table, time and handle counters, serial minimum search, output stage.
// ----------------------------------------------------------------------------
module tqs_datapath
   import tqs_pkg::*;
#(
   parameter int SLOTS       = SLOTS_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  tqs_cmd_type cmd,
   output tqs_sts_type sts,
   input  logic [26:0] req_delay_ms,
   input  logic [26:0] req_period_ms,
   input  logic [15:0] req_target_handle,
   output logic        out_busy,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_handle,
   output logic        rsp_status,
   output logic        rsp_last_of_run
);
   localparam int IW = $clog2(SLOTS);
   // common width for matching a stored handle against a request handle
   localparam int CW = (HANDLE_BITS > 16) ? HANDLE_BITS : 16;

   logic                   valid_ff [SLOTS];
   logic [HANDLE_BITS-1:0] hnd_ff   [SLOTS];
   logic [TIME_BITS-1:0]   due_ff   [SLOTS];
   logic [26:0]            per_ff   [SLOTS];

   logic [TIME_BITS-1:0]   now_ff;
   logic [HANDLE_BITS-1:0] next_ff;
   logic [26:0]            delay_ff, period_ff;
   logic [15:0]            target_ff;

   // serial search state: pending bits frozen at tick time
   logic                   pend_ff [SLOTS];
   logic [IW-1:0]          idx_ff;
   logic                   found_ff;
   logic [IW-1:0]          best_ff;
   logic [TIME_BITS-1:0]   bdue_ff;
   logic [HANDLE_BITS-1:0] bhnd_ff;

   // output register
   logic        ov_ff, okind_ff, ostat_ff, olast_ff;
   logic [15:0] ohnd_ff;

   // lowest free slot, any-pending after this pick
   logic          free_ok;
   logic [IW-1:0] free_idx;
   logic          more;
   logic [IW-1:0] cur;
   logic          better;
   logic [26:0]   dsat, psat;

   always_comb begin
      free_ok  = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_ok  = 1'b1;
            free_idx = IW'(i);
         end
      end
      more = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (pend_ff[i] && IW'(i) != best_ff) more = 1'b1;
      end
   end

   assign cur    = idx_ff;
   assign better = pend_ff[cur] && (!found_ff || due_ff[cur] < bdue_ff ||
                   (due_ff[cur] == bdue_ff && hnd_ff[cur] < bhnd_ff));
   assign dsat   = (delay_ff  > DAY_MS) ? DAY_MS : delay_ff;
   assign psat   = (period_ff > DAY_MS) ? DAY_MS : period_ff;

   assign sts.scan_done = (idx_ff == IW'(SLOTS - 1)) && cmd.scan_step;
   assign sts.found     = found_ff;
   assign out_busy      = ov_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff  <= '0;
         next_ff <= HANDLE_BITS'(1);
         ov_ff   <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
            pend_ff[i]  <= 1'b0;
         end
      end else begin
         if (cmd.do_add || cmd.fire) ov_ff <= 1'b1;
         else if (ov_ff && rsp_ready) ov_ff <= 1'b0;
         if (cmd.load) begin
            delay_ff  <= req_delay_ms;
            period_ff <= req_period_ms;
            target_ff <= req_target_handle;
         end
         // tick: advance time and freeze the due set
         if (cmd.load && cmd.scan_clr) begin
            now_ff <= now_ff + 1'b1;
            for (int i = 0; i < SLOTS; i++)
               pend_ff[i] <= valid_ff[i] && (due_ff[i] <= now_ff + 1'b1);
         end
         if (cmd.do_cancel) begin
            for (int i = 0; i < SLOTS; i++)
               if (CW'(hnd_ff[i]) == CW'(target_ff))
                  valid_ff[i] <= 1'b0;
         end
         if (cmd.do_clear) begin
            for (int i = 0; i < SLOTS; i++) valid_ff[i] <= 1'b0;
         end
         if (cmd.do_add) begin
            okind_ff <= KIND_ADD;
            olast_ff <= 1'b1;
            ostat_ff <= !free_ok;
            ohnd_ff  <= free_ok ? 16'(next_ff) : 16'd0;
            if (free_ok) begin
               valid_ff[free_idx] <= 1'b1;
               hnd_ff[free_idx]   <= next_ff;
               due_ff[free_idx]   <= now_ff + TIME_BITS'(dsat);
               per_ff[free_idx]   <= psat;
               next_ff <= (next_ff + 1'b1 == '0) ? HANDLE_BITS'(1) : next_ff + 1'b1;
            end
         end
         if (cmd.fire) begin
            okind_ff <= KIND_FIRED;
            ostat_ff <= 1'b0;
            olast_ff <= !more;
            ohnd_ff  <= 16'(bhnd_ff);
            pend_ff[best_ff] <= 1'b0;
            if (per_ff[best_ff] != '0)
               due_ff[best_ff] <= now_ff + TIME_BITS'(per_ff[best_ff]);
            else
               valid_ff[best_ff] <= 1'b0;
         end
      end
   end

   // search registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_clr) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff <= (idx_ff == IW'(SLOTS - 1)) ? '0 : idx_ff + 1'b1;
         if (better) begin
            found_ff <= 1'b1;
            best_ff  <= cur;
            bdue_ff  <= due_ff[cur];
            bhnd_ff  <= hnd_ff[cur];
         end
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_kind        = okind_ff;
   assign rsp_handle      = ohnd_ff;
   assign rsp_status      = ostat_ff;
   assign rsp_last_of_run = olast_ff;

`include "timer_queue_scheduler_defines.svh"
   `TQS_ASSERT_IMP(a_fire_found, cmd.fire, found_ff, "fire without a pending slot")
   `TQS_ASSERT_IMP(a_no_overwrite, cmd.fire || cmd.do_add, !out_busy, "output overwritten")
   `TQS_ASSERT_NEXT(a_fire_out, cmd.fire, ov_ff && okind_ff == KIND_FIRED, "fire lost")
endmodule

>>> hdl/timer_queue_scheduler.sv
// ----------------------------------------------------------------------------
// timer_queue_scheduler
// Table of millisecond timers: add, cancel, clear, tick with ordered firing.
// ----------------------------------------------------------------------------
// channel  direction  payload
// req_     in         operation, delay_ms, period_ms, target_handle
// rsp_     out        kind, handle, status, last_of_run
//
// Add, cancel and clear pass through an operation state; a tick runs one serial
// minimum search over the slot table per fired timer, plus one that finds none.
// Reset clears time and all slot valid bits and sets the handle counter to one
// at once. A stalled rsp_ holds the sequencer before the next result.
module timer_queue_scheduler
   import tqs_pkg::*;
#(
   parameter int SLOTS       = SLOTS_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [26:0] req_delay_ms,
   input  logic [26:0] req_period_ms,
   input  logic [15:0] req_target_handle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_handle,
   output logic        rsp_status,
   output logic        rsp_last_of_run
);
   tqs_cmd_type cmd;
   tqs_sts_type sts;
   logic        out_busy;

   // sequence each request
   tqs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_operation,
      .out_busy, .sts, .cmd
   );

   // hold the table and drive results
   tqs_datapath #(
      .SLOTS(SLOTS), .HANDLE_BITS(HANDLE_BITS), .TIME_BITS(TIME_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .sts, .req_delay_ms, .req_period_ms,
      .req_target_handle, .out_busy, .rsp_valid, .rsp_ready, .rsp_kind,
      .rsp_handle, .rsp_status, .rsp_last_of_run
   );
endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timer queue scheduler: a software timer table
// predicts every fired-timer and add-reply result, which a checker compares
// field by field against the block's result channel.
// ----------------------------------------------------------------------------
module testbench
   import tqs_pkg::*;
();

   localparam int NSLOT  = 16;
   localparam logic [39:0] TMASK = 40'hFF_FFFF_FFFF;
   localparam longint LIMIT = 2_000_000;

   typedef struct packed {
      logic        kind;
      logic [15:0] handle;
      logic        status;
      logic        last;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_TICK;
   logic [26:0] req_delay_ms = '0;
   logic [26:0] req_period_ms = '0;
   logic [15:0] req_target_handle = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [15:0] rsp_handle;
   logic        rsp_status;
   logic        rsp_last_of_run;

   timer_queue_scheduler dut (.*);

   always #4 clock = ~clock;

   // predictor state: a copy of the timer table
   logic        tbl_used [NSLOT];
   logic [15:0] tbl_handle [NSLOT];
   logic [39:0] tbl_due [NSLOT];
   logic [26:0] tbl_period [NSLOT];
   logic [39:0] clock_ms;
   logic [15:0] handle_ctr;

   result_type expected_results[$];
   int      mismatches = 0;
   longint  cycles = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_asks = 0;
   int      hold_taken = 0;
   int      hold_off = 0;

   // append one expectation at the tail of the queue
   task automatic expect_result(result_type r);
      expected_results = {expected_results, r};
   endtask

   // fire every due timer in (due, handle, slot) order
   task automatic predict_tick();
      logic pend [NSLOT];
      int best;
      int n;
      n = 0;
      clock_ms = (clock_ms + 1) & TMASK;
      for (int i = 0; i < NSLOT; i++) pend[i] = tbl_used[i] && tbl_due[i] <= clock_ms;
      forever begin
         best = -1;
         for (int i = 0; i < NSLOT; i++)
            if (pend[i] && (best < 0 || tbl_due[i] < tbl_due[best] ||
                (tbl_due[i] == tbl_due[best] && tbl_handle[i] < tbl_handle[best])))
               best = i;
         if (best < 0) break;
         pend[best] = 1'b0;
         expect_result('{KIND_FIRED, tbl_handle[best], 1'b0, 1'b0});
         n++;
         if (tbl_period[best] != 0) tbl_due[best] = (clock_ms + tbl_period[best]) & TMASK;
         else tbl_used[best] = 1'b0;
      end
      if (n > 0) expected_results[$].last = 1'b1;
   endtask

   task automatic predict_request(logic [1:0] op, logic [26:0] dly, logic [26:0] per,
                                  logic [15:0] tgt);
      int slot;
      slot = -1;
      case (op)
         OP_TICK: predict_tick();
         OP_ADD: begin
            for (int i = NSLOT - 1; i >= 0; i--) if (!tbl_used[i]) slot = i;
            if (slot < 0) begin
               expect_result('{KIND_ADD, 16'd0, 1'b1, 1'b1});
            end else begin
               if (dly > DAY_MS) dly = DAY_MS;
               if (per > DAY_MS) per = DAY_MS;
               tbl_used[slot] = 1'b1;
               tbl_handle[slot] = handle_ctr;
               tbl_due[slot] = (clock_ms + dly) & TMASK;
               tbl_period[slot] = per;
               expect_result('{KIND_ADD, handle_ctr, 1'b0, 1'b1});
               handle_ctr = handle_ctr + 1;
               if (handle_ctr == 0) handle_ctr = 1;
            end
         end
         OP_CANCEL: begin
            for (int i = 0; i < NSLOT; i++)
               if (tbl_used[i] && tbl_handle[i] == tgt) tbl_used[i] = 1'b0;
         end
         default: begin
            for (int i = 0; i < NSLOT; i++) tbl_used[i] = 1'b0;
         end
      endcase
   endtask

   // offer one request, hold it until accepted, then predict its results
   task automatic send_request(logic [1:0] op, logic [26:0] dly = 0, logic [26:0] per = 0,
                               logic [15:0] tgt = 0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_delay_ms <= dly;
      req_period_ms <= per;
      req_target_handle <= tgt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(op, dly, per, tgt);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [15:0] live_handle();
      int i;
      i = $urandom_range(NSLOT - 1);
      return tbl_used[i] ? tbl_handle[i] : 16'($urandom_range(handle_ctr));
   endfunction

   // drive the receiver: random stalls plus a counted hold-off
   always @(posedge clock) begin
      if (hold_asks != hold_taken) begin
         hold_taken <= hold_taken + 1;
         hold_off <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      result_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_kind, rsp_handle, rsp_status, rsp_last_of_run};
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // extremes, every operation, saturation, zero delay, duplicates, full table
   task automatic test_directed();
      send_request(OP_ADD, 27'd0, 27'd0);
      send_request(OP_ADD, 27'h7FFFFFF, 27'h7FFFFFF);
      send_request(OP_ADD, DAY_MS, 27'd1);
      send_request(OP_TICK);
      send_request(OP_TICK);
      send_request(OP_CANCEL, 0, 0, 16'd3);
      send_request(OP_CANCEL, 0, 0, 16'hFFFF);
      send_request(OP_TICK);
      for (int i = 0; i < 17; i++) send_request(OP_ADD, 27'(i % 3), 27'(i % 2));
      send_request(OP_TICK);
      send_request(OP_TICK);
      send_request(OP_CLEAR, 27'h7FFFFFF, 27'h7FFFFFF, 16'hFFFF);
      send_request(OP_TICK);
      wait_drained();
   endtask

   // mostly adds with short delays and ticks, some cancels and clears
   task automatic test_random(int count);
      int r;
      logic [26:0] d, p;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         d = ($urandom_range(9) == 0) ? 27'($urandom) : 27'($urandom_range(6));
         p = ($urandom_range(9) == 0) ? 27'($urandom) : 27'($urandom_range(4));
         if (r < 45) send_request(OP_TICK, 27'($urandom), 27'($urandom), 16'($urandom));
         else if (r < 80) send_request(OP_ADD, d, p, 16'($urandom));
         else if (r < 96) send_request(OP_CANCEL, d, p, live_handle());
         else send_request(OP_CLEAR, d, p, 16'($urandom));
      end
   endtask

   // stall the receiver long while the sender keeps offering fired timers
   task automatic test_backpressure();
      hold_asks <= hold_asks + 1;
      for (int i = 0; i < 14; i++) send_request(OP_ADD, 27'd1, 27'd1);
      repeat (10) send_request(OP_TICK);
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++) tbl_used[i] = 1'b0;
      clock_ms = '0;
      handle_ctr = 16'd1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 0;  recv_stall_pct = 0;  test_random(80); wait_drained();
      send_idle_pct = 65; recv_stall_pct = 0;  test_random(60); wait_drained();
      send_idle_pct = 0;  recv_stall_pct = 65; test_random(60); wait_drained();
      send_idle_pct = 15; recv_stall_pct = 15; test_random(60); wait_drained();
      send_idle_pct = 0;  recv_stall_pct = 0;
      test_backpressure();
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule

>>> files.f
+incdir+hdl
hdl/tqs_pkg.sv
hdl/tqs_ctrl.sv
hdl/tqs_datapath.sv
hdl/timer_queue_scheduler.sv
test/testbench.sv
